// ===== src/twn_pkg.sv =====
// shared types and constants for the triangle world transform and normal core
package twn_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int CFG_W           = 48;
    localparam int CFG_IDX_W       = 4;
    localparam int COMP_W          = 16;
    localparam int WORLD_W         = 18;
    localparam int NORM_W          = 16;
    localparam int DIFF_W          = WORLD_W + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int CROSS_W         = PROD_W + 1;
    localparam int MAG_W           = 31;
    localparam int ABS_W           = CROSS_W - 1;
    localparam int SHIFT_W         = 3;
    localparam int SQ_W            = 2 * MAG_W;
    localparam int SUM_W           = 64;
    localparam int ROOT_W          = 32;
    localparam int SQRT_STAGES     = ROOT_W;
    localparam int QUO_W           = 15;
    localparam int NUM_W           = MAG_W + 15;
    localparam int REM_W           = ROOT_W + 2;
    localparam int FRAC_SHIFT      = 14;
    localparam int WORLD_MAX       = 131071;
    localparam int WORLD_MIN       = -131072;

    localparam logic [CFG_IDX_W-1:0] REG_BASIS_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN  = 4'd3;

    localparam logic [CFG_W-1:0] BASIS_X_RESET = 48'd16384;
    localparam logic [CFG_W-1:0] BASIS_Y_RESET = 48'd16384 << 16;
    localparam logic [CFG_W-1:0] BASIS_Z_RESET = 48'd16384 << 32;
    localparam logic [CFG_W-1:0] ORIGIN_RESET  = 48'd0;

    localparam logic [1:0] LAST_VERTEX = 2'd2;

    typedef struct packed {
        logic [2:0][2:0][WORLD_W-1:0] world;
        logic [2:0]                   neg;
        logic                         zero;
        logic                         mesh_end;
    } side_t;

endpackage

// ===== src/triangle_world_transform_normal_core.sv =====
// top level: config registers and the transform, cross, sqrt, divide and output stages
// the single result port sends the three vertex results of each triangle in turn, one per
// cycle while m_ready is high; a triangle in the last stage waits until the last is taken
// the pipeline takes a new triangle every cycle while the output register has room
// reset: synchronous active-low aresetn clears all valid bits and loads the default basis
// (identity axes) and a zero origin
module triangle_world_transform_normal_core #(
    parameter int COORD_WIDTH = twn_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [twn_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [twn_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [COORD_WIDTH-1:0]          s_a_x,
    input  logic signed [COORD_WIDTH-1:0]          s_a_y,
    input  logic signed [COORD_WIDTH-1:0]          s_a_z,
    input  logic signed [COORD_WIDTH-1:0]          s_b_x,
    input  logic signed [COORD_WIDTH-1:0]          s_b_y,
    input  logic signed [COORD_WIDTH-1:0]          s_b_z,
    input  logic signed [COORD_WIDTH-1:0]          s_c_x,
    input  logic signed [COORD_WIDTH-1:0]          s_c_y,
    input  logic signed [COORD_WIDTH-1:0]          s_c_z,
    input  logic                                   s_mesh_end_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [twn_pkg::WORLD_W-1:0]     m_world_x,
    output logic signed [twn_pkg::WORLD_W-1:0]     m_world_y,
    output logic signed [twn_pkg::WORLD_W-1:0]     m_world_z,
    output logic signed [twn_pkg::NORM_W-1:0]      m_normal_x,
    output logic signed [twn_pkg::NORM_W-1:0]      m_normal_y,
    output logic signed [twn_pkg::NORM_W-1:0]      m_normal_z,
    output logic                                   m_vertex_last,
    output logic                                   m_mesh_end_out
);
    logic [2:0][twn_pkg::CFG_W-1:0]        basis_reg;
    logic [twn_pkg::CFG_W-1:0]             origin_reg;
    logic [2:0][2:0][COORD_WIDTH-1:0]      coord;
    logic                                  en;
    logic                                  ser_free;

    logic                                  xf_valid;
    twn_pkg::side_t                        xf_side;
    logic                                  cr_valid;
    twn_pkg::side_t                        cr_side;
    logic [2:0][twn_pkg::MAG_W-1:0]        cr_mag;
    logic [twn_pkg::SUM_W-1:0]             cr_sum;
    logic                                  sq_valid;
    twn_pkg::side_t                        sq_side;
    logic [2:0][twn_pkg::MAG_W-1:0]        sq_mag;
    logic [twn_pkg::ROOT_W-1:0]            sq_root;
    logic                                  dv_valid;
    twn_pkg::side_t                        dv_side;
    logic [2:0][twn_pkg::QUO_W-1:0]        dv_quo;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            basis_reg[0] <= twn_pkg::BASIS_X_RESET;
            basis_reg[1] <= twn_pkg::BASIS_Y_RESET;
            basis_reg[2] <= twn_pkg::BASIS_Z_RESET;
            origin_reg   <= twn_pkg::ORIGIN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                twn_pkg::REG_BASIS_X: basis_reg[0] <= cfg_data;
                twn_pkg::REG_BASIS_Y: basis_reg[1] <= cfg_data;
                twn_pkg::REG_BASIS_Z: basis_reg[2] <= cfg_data;
                twn_pkg::REG_ORIGIN:  origin_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline moves whenever the last stage is empty or the output register takes it
    assign en      = ser_free || !dv_valid;
    assign s_ready = en;

    assign coord[0] = {s_a_z, s_a_y, s_a_x};
    assign coord[1] = {s_b_z, s_b_y, s_b_x};
    assign coord[2] = {s_c_z, s_c_y, s_c_x};

    twn_xform #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .coord     (coord),
        .mesh_end  (s_mesh_end_in),
        .basis     (basis_reg),
        .origin    (origin_reg),
        .out_valid (xf_valid),
        .out_side  (xf_side)
    );

    twn_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (xf_valid),
        .in_side   (xf_side),
        .out_valid (cr_valid),
        .out_side  (cr_side),
        .out_mag   (cr_mag),
        .out_sum   (cr_sum)
    );

    twn_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cr_valid),
        .in_side   (cr_side),
        .in_mag    (cr_mag),
        .in_sum    (cr_sum),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_mag   (sq_mag),
        .out_root  (sq_root)
    );

    twn_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_mag    (sq_mag),
        .in_root   (sq_root),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    twn_ser u_ser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (dv_valid),
        .in_side        (dv_side),
        .in_quo         (dv_quo),
        .free           (ser_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_world_x      (m_world_x),
        .m_world_y      (m_world_y),
        .m_world_z      (m_world_z),
        .m_normal_x     (m_normal_x),
        .m_normal_y     (m_normal_y),
        .m_normal_z     (m_normal_z),
        .m_vertex_last  (m_vertex_last),
        .m_mesh_end_out (m_mesh_end_out)
    );
endmodule

// ===== src/twn_xform.sv =====
// local to world vertex transform: product stage then round, offset and saturate stage
module twn_xform #(
    parameter int COORD_WIDTH = twn_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [2:0][2:0][COORD_WIDTH-1:0]     coord,
    input  logic                                 mesh_end,
    input  logic [2:0][twn_pkg::CFG_W-1:0]       basis,
    input  logic [twn_pkg::CFG_W-1:0]            origin,
    output logic                                 out_valid,
    output twn_pkg::side_t                       out_side
);
    localparam int PW = COORD_WIDTH + twn_pkg::COMP_W;
    localparam int AW = PW + 2;
    localparam int RW = AW - twn_pkg::FRAC_SHIFT;
    localparam int EW = ((RW > twn_pkg::WORLD_W - 1) ? RW : twn_pkg::WORLD_W - 1) + 1;
    localparam logic signed [EW-1:0] WMAX = EW'(twn_pkg::WORLD_MAX);
    localparam logic signed [EW-1:0] WMIN = EW'(twn_pkg::WORLD_MIN);

    logic signed [PW-1:0] prod_reg  [3][3][3];
    logic signed [PW-1:0] prod_next [3][3][3];
    logic                 valid1_reg;
    logic                 mesh1_reg;
    logic                 valid2_reg;
    twn_pkg::side_t       side2_reg;
    twn_pkg::side_t       side2_next;
    logic signed [AW-1:0] acc [3][3];
    logic signed [EW-1:0] sum [3][3];

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_next[v][k][j] = PW'($signed(coord[v][j])
                        * $signed(basis[j][twn_pkg::COMP_W*k +: twn_pkg::COMP_W]));
                end
            end
        end
    end

    always_comb begin
        side2_next          = '0;
        side2_next.mesh_end = mesh1_reg;
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                acc[v][k] = AW'(prod_reg[v][k][0]) + AW'(prod_reg[v][k][1])
                          + AW'(prod_reg[v][k][2]) + AW'(8192);
                sum[v][k] = EW'($signed(acc[v][k][AW-1:twn_pkg::FRAC_SHIFT]))
                          + EW'($signed(origin[twn_pkg::COMP_W*k +: twn_pkg::COMP_W]));
                if (sum[v][k] > WMAX) begin
                    side2_next.world[v][k] = twn_pkg::WORLD_W'(WMAX);
                end else if (sum[v][k] < WMIN) begin
                    side2_next.world[v][k] = twn_pkg::WORLD_W'(WMIN);
                end else begin
                    side2_next.world[v][k] = twn_pkg::WORLD_W'(sum[v][k]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            mesh1_reg <= mesh_end;
            side2_reg <= side2_next;
        end
    end

    assign out_valid = valid2_reg;
    assign out_side  = side2_reg;
endmodule

// ===== src/twn_cross.sv =====
// edge vectors, cross product, magnitude scaling and sum of squares
module twn_cross (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  twn_pkg::side_t                         in_side,
    output logic                                   out_valid,
    output twn_pkg::side_t                         out_side,
    output logic [2:0][twn_pkg::MAG_W-1:0]         out_mag,
    output logic [twn_pkg::SUM_W-1:0]              out_sum
);
    localparam int STAGES = 6;

    logic [STAGES-1:0] valid_reg;
    twn_pkg::side_t    side_reg [STAGES];

    logic signed [twn_pkg::DIFF_W-1:0]  d1_reg [3];
    logic signed [twn_pkg::DIFF_W-1:0]  d2_reg [3];
    logic signed [twn_pkg::PROD_W-1:0]  p_reg  [6];
    logic signed [twn_pkg::CROSS_W-1:0] n_reg  [3];
    logic [twn_pkg::MAG_W-1:0]          m4_reg [3];
    logic [twn_pkg::MAG_W-1:0]          m5_reg [3];
    logic [twn_pkg::MAG_W-1:0]          m6_reg [3];
    logic [twn_pkg::SQ_W-1:0]           sq_reg [3];
    logic [twn_pkg::SUM_W-1:0]          sum_reg;

    logic signed [twn_pkg::DIFF_W-1:0]  d1_next [3];
    logic signed [twn_pkg::DIFF_W-1:0]  d2_next [3];
    logic [twn_pkg::ABS_W-1:0]          mag     [3];
    logic [twn_pkg::ABS_W-1:0]          mx;
    logic [twn_pkg::SHIFT_W-1:0]        sh;
    logic [twn_pkg::MAG_W-1:0]          m_next  [3];
    twn_pkg::side_t                     side4_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d1_next[k] = twn_pkg::DIFF_W'($signed(in_side.world[1][k]))
                       - twn_pkg::DIFF_W'($signed(in_side.world[0][k]));
            d2_next[k] = twn_pkg::DIFF_W'($signed(in_side.world[2][k]))
                       - twn_pkg::DIFF_W'($signed(in_side.world[0][k]));
        end
    end

    always_comb begin
        side4_next = side_reg[2];
        mx         = '0;
        sh         = '0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = n_reg[k][twn_pkg::CROSS_W-1]
                   ? twn_pkg::ABS_W'(-n_reg[k]) : twn_pkg::ABS_W'(n_reg[k]);
            side4_next.neg[k] = n_reg[k][twn_pkg::CROSS_W-1];
            if (mag[k] > mx) begin
                mx = mag[k];
            end
        end
        for (int i = 1; i <= twn_pkg::ABS_W - twn_pkg::MAG_W; i++) begin
            if (mx[twn_pkg::MAG_W - 1 + i]) begin
                sh = twn_pkg::SHIFT_W'(i);
            end
        end
        side4_next.zero = (mx == '0);
        for (int k = 0; k < 3; k++) begin
            m_next[k] = twn_pkg::MAG_W'(mag[k] >> sh);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side4_next;
            side_reg[4] <= side_reg[3];
            side_reg[5] <= side_reg[4];
            d1_reg      <= d1_next;
            d2_reg      <= d2_next;
            p_reg[0]    <= twn_pkg::PROD_W'(d1_reg[1] * d2_reg[2]);
            p_reg[1]    <= twn_pkg::PROD_W'(d1_reg[2] * d2_reg[1]);
            p_reg[2]    <= twn_pkg::PROD_W'(d1_reg[2] * d2_reg[0]);
            p_reg[3]    <= twn_pkg::PROD_W'(d1_reg[0] * d2_reg[2]);
            p_reg[4]    <= twn_pkg::PROD_W'(d1_reg[0] * d2_reg[1]);
            p_reg[5]    <= twn_pkg::PROD_W'(d1_reg[1] * d2_reg[0]);
            n_reg[0]    <= twn_pkg::CROSS_W'(p_reg[0]) - twn_pkg::CROSS_W'(p_reg[1]);
            n_reg[1]    <= twn_pkg::CROSS_W'(p_reg[2]) - twn_pkg::CROSS_W'(p_reg[3]);
            n_reg[2]    <= twn_pkg::CROSS_W'(p_reg[4]) - twn_pkg::CROSS_W'(p_reg[5]);
            m4_reg      <= m_next;
            m5_reg      <= m4_reg;
            m6_reg      <= m5_reg;
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= twn_pkg::SQ_W'(m4_reg[k]) * twn_pkg::SQ_W'(m4_reg[k]);
            end
            sum_reg     <= twn_pkg::SUM_W'(sq_reg[0]) + twn_pkg::SUM_W'(sq_reg[1])
                         + twn_pkg::SUM_W'(sq_reg[2]);
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_sum   = sum_reg;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            out_mag[k] = m6_reg[k];
        end
    end
endmodule

// ===== src/twn_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module twn_sqrt (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  twn_pkg::side_t                         in_side,
    input  logic [2:0][twn_pkg::MAG_W-1:0]         in_mag,
    input  logic [twn_pkg::SUM_W-1:0]              in_sum,
    output logic                                   out_valid,
    output twn_pkg::side_t                         out_side,
    output logic [2:0][twn_pkg::MAG_W-1:0]         out_mag,
    output logic [twn_pkg::ROOT_W-1:0]             out_root
);
    localparam int N = twn_pkg::SQRT_STAGES;
    localparam int W = twn_pkg::SUM_W;

    logic [N-1:0]                      valid_reg;
    twn_pkg::side_t                    side_reg [N];
    logic [2:0][twn_pkg::MAG_W-1:0]    mag_reg  [N];
    logic [W-1:0]                      rem_reg  [N];
    logic [W-1:0]                      root_reg [N];
    logic [W-1:0]                      rem_next  [N];
    logic [W-1:0]                      root_next [N];
    logic [W-1:0]                      rem_in;
    logic [W-1:0]                      root_in;
    logic [W-1:0]                      bit_val;
    logic [W-1:0]                      trial;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            rem_in  = (i == 0) ? in_sum : rem_reg[(i == 0) ? 0 : i - 1];
            root_in = (i == 0) ? '0     : root_reg[(i == 0) ? 0 : i - 1];
            bit_val = W'(1) << (W - 2 - 2 * i);
            trial   = root_in + bit_val;
            if (rem_in >= trial) begin
                rem_next[i]  = rem_in - trial;
                root_next[i] = (root_in >> 1) + bit_val;
            end else begin
                rem_next[i]  = rem_in;
                root_next[i] = root_in >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                side_reg[i] <= (i == 0) ? in_side : side_reg[(i == 0) ? 0 : i - 1];
                mag_reg[i]  <= (i == 0) ? in_mag  : mag_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_mag   = mag_reg[N-1];
    assign out_root  = twn_pkg::ROOT_W'(root_reg[N-1]);
endmodule

// ===== src/twn_div.sv =====
// rounded scaling divide, three lanes, one quotient bit per stage after the numerator setup stage
module twn_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  twn_pkg::side_t                         in_side,
    input  logic [2:0][twn_pkg::MAG_W-1:0]         in_mag,
    input  logic [twn_pkg::ROOT_W-1:0]             in_root,
    output logic                                   out_valid,
    output twn_pkg::side_t                         out_side,
    output logic [2:0][twn_pkg::QUO_W-1:0]         out_quo
);
    localparam int N  = twn_pkg::QUO_W + 1;
    localparam int QW = twn_pkg::QUO_W;
    localparam int RW = twn_pkg::REM_W;

    logic [N-1:0]                 valid_reg;
    twn_pkg::side_t               side_reg [N];
    logic [twn_pkg::ROOT_W-1:0]   len_reg  [N];
    logic [2:0][RW-1:0]           rem_reg  [N];
    logic [2:0][QW-1:0]           low_reg  [N];
    logic [2:0][QW-1:0]           quo_reg  [N];
    logic [2:0][RW-1:0]           rem_next [N];
    logic [2:0][QW-1:0]           quo_next [N];
    logic [twn_pkg::NUM_W-1:0]    num;
    logic [RW-1:0]                shifted;
    logic [RW-1:0]                len_ext;

    always_comb begin
        rem_next[0] = '0;
        quo_next[0] = '0;
        for (int k = 0; k < 3; k++) begin
            num = {in_mag[k], 14'd0} + twn_pkg::NUM_W'(in_root >> 1);
            rem_next[0][k] = RW'(num >> QW);
        end
        for (int i = 1; i < N; i++) begin
            len_ext = RW'(len_reg[i-1]);
            for (int k = 0; k < 3; k++) begin
                shifted = {rem_reg[i-1][k][RW-2:0], low_reg[i-1][k][QW - i]};
                if (shifted >= len_ext) begin
                    rem_next[i][k] = shifted - len_ext;
                    quo_next[i][k] = {quo_reg[i-1][k][QW-2:0], 1'b1};
                end else begin
                    rem_next[i][k] = shifted;
                    quo_next[i][k] = {quo_reg[i-1][k][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            len_reg[0]  <= in_root;
            for (int k = 0; k < 3; k++) begin
                low_reg[0][k] <= QW'({in_mag[k], 14'd0} + twn_pkg::NUM_W'(in_root >> 1));
            end
            for (int i = 1; i < N; i++) begin
                side_reg[i] <= side_reg[i-1];
                len_reg[i]  <= len_reg[i-1];
                low_reg[i]  <= low_reg[i-1];
            end
            for (int i = 0; i < N; i++) begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_quo   = quo_reg[N-1];
endmodule

// ===== src/twn_ser.sv =====
// result register that sends the three vertex results of a triangle
module twn_ser (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    input  twn_pkg::side_t                         in_side,
    input  logic [2:0][twn_pkg::QUO_W-1:0]         in_quo,
    output logic                                   free,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [twn_pkg::WORLD_W-1:0]     m_world_x,
    output logic signed [twn_pkg::WORLD_W-1:0]     m_world_y,
    output logic signed [twn_pkg::WORLD_W-1:0]     m_world_z,
    output logic signed [twn_pkg::NORM_W-1:0]      m_normal_x,
    output logic signed [twn_pkg::NORM_W-1:0]      m_normal_y,
    output logic signed [twn_pkg::NORM_W-1:0]      m_normal_z,
    output logic                                   m_vertex_last,
    output logic                                   m_mesh_end_out
);
    logic                                   valid_reg;
    logic [1:0]                             idx_reg;
    logic [2:0][twn_pkg::WORLD_W-1:0]       world_reg [3];
    logic [2:0][twn_pkg::NORM_W-1:0]        normal_reg;
    logic [2:0][twn_pkg::NORM_W-1:0]        normal_next;
    logic                                   mesh_reg;
    logic                                   last;
    logic                                   load;

    assign last = (idx_reg == twn_pkg::LAST_VERTEX);
    assign free = !valid_reg || (m_ready && last);
    assign load = free && in_valid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (in_side.zero) begin
                normal_next[k] = '0;
            end else if (in_side.neg[k]) begin
                normal_next[k] = -twn_pkg::NORM_W'(in_quo[k]);
            end else begin
                normal_next[k] = twn_pkg::NORM_W'(in_quo[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (free) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (m_ready) begin
            idx_reg   <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int v = 0; v < 3; v++) begin
                world_reg[v] <= in_side.world[v];
            end
            normal_reg <= normal_next;
            mesh_reg   <= in_side.mesh_end;
        end
    end

    assign m_valid        = valid_reg;
    assign m_world_x      = world_reg[idx_reg][0];
    assign m_world_y      = world_reg[idx_reg][1];
    assign m_world_z      = world_reg[idx_reg][2];
    assign m_normal_x     = normal_reg[0];
    assign m_normal_y     = normal_reg[1];
    assign m_normal_z     = normal_reg[2];
    assign m_vertex_last  = last;
    assign m_mesh_end_out = mesh_reg;
endmodule

// ===== dv/twn_checker.sv =====
// checker for the triangle world transform and normal core: predicts and compares results
`timescale 1ns / 1ps
module twn_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [twn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [twn_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [15:0]                  s_a_x,
    input  logic signed [15:0]                  s_a_y,
    input  logic signed [15:0]                  s_a_z,
    input  logic signed [15:0]                  s_b_x,
    input  logic signed [15:0]                  s_b_y,
    input  logic signed [15:0]                  s_b_z,
    input  logic signed [15:0]                  s_c_x,
    input  logic signed [15:0]                  s_c_y,
    input  logic signed [15:0]                  s_c_z,
    input  logic                                s_mesh_end_in,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [twn_pkg::WORLD_W-1:0]  m_world_x,
    input  logic signed [twn_pkg::WORLD_W-1:0]  m_world_y,
    input  logic signed [twn_pkg::WORLD_W-1:0]  m_world_z,
    input  logic signed [twn_pkg::NORM_W-1:0]   m_normal_x,
    input  logic signed [twn_pkg::NORM_W-1:0]   m_normal_y,
    input  logic signed [twn_pkg::NORM_W-1:0]   m_normal_z,
    input  logic                                m_vertex_last,
    input  logic                                m_mesh_end_out,
    output int                                  fail_count,
    output int                                  pending
);
    typedef struct {
        logic signed [twn_pkg::WORLD_W-1:0] wx, wy, wz;
        logic signed [twn_pkg::NORM_W-1:0]  nx, ny, nz;
        logic                               last, mend;
    } vertex_result_t;

    vertex_result_t  vertex_q[$];
    logic [twn_pkg::CFG_W-1:0] axis_x, axis_y, axis_z, org;

    assign pending = vertex_q.size();

    function automatic longint comp16(logic [twn_pkg::CFG_W-1:0] r, int k);
        logic signed [15:0] c;
        c = r[16*k +: 16];
        return longint'(c);
    endfunction

    function automatic longint world_coord(longint x, longint y, longint z, int k);
        longint acc, v;
        acc = x * comp16(axis_x, k) + y * comp16(axis_y, k) + z * comp16(axis_z, k);
        v = ((acc + 8192) >>> 14) + comp16(org, k);
        if (v > twn_pkg::WORLD_MAX) v = twn_pkg::WORLD_MAX;
        if (v < twn_pkg::WORLD_MIN) v = twn_pkg::WORLD_MIN;
        return v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_triangle(longint p[9], logic mend);
        longint w[3][3], d1[3], d2[3], n[3], q[3];
        longint unsigned mag[3], mx, sum, len, r;
        int s;
        vertex_result_t e;
        for (int v = 0; v < 3; v++)
            for (int k = 0; k < 3; k++)
                w[v][k] = world_coord(p[3*v], p[3*v+1], p[3*v+2], k);
        for (int k = 0; k < 3; k++) begin
            d1[k] = w[1][k] - w[0][k];
            d2[k] = w[2][k] - w[0][k];
        end
        n[0] = d1[1] * d2[2] - d1[2] * d2[1];
        n[1] = d1[2] * d2[0] - d1[0] * d2[2];
        n[2] = d1[0] * d2[1] - d1[1] * d2[0];
        mx = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = (n[k] < 0) ? -n[k] : n[k];
            if (mag[k] > mx) mx = mag[k];
        end
        if (mx == 0) begin
            q[0] = 0; q[1] = 0; q[2] = 0;
        end else begin
            s = 0;
            while ((mx >> s) >= (64'd1 << 31)) s++;
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                mag[k] >>= s;
                sum += mag[k] * mag[k];
            end
            len = floor_sqrt(sum);
            for (int k = 0; k < 3; k++) begin
                r = (mag[k] * 16384 + (len >> 1)) / len;
                q[k] = (n[k] < 0) ? -longint'(r) : longint'(r);
            end
        end
        for (int v = 0; v < 3; v++) begin
            e.wx = twn_pkg::WORLD_W'(w[v][0]);
            e.wy = twn_pkg::WORLD_W'(w[v][1]);
            e.wz = twn_pkg::WORLD_W'(w[v][2]);
            e.nx = twn_pkg::NORM_W'(q[0]);
            e.ny = twn_pkg::NORM_W'(q[1]);
            e.nz = twn_pkg::NORM_W'(q[2]);
            e.last = (v == 2);
            e.mend = mend;
            vertex_q.push_back(e);
        end
    endtask

    task automatic report(string what, longint got, longint exp_v);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $time);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        longint p[9];
        vertex_result_t e;
        if (!aresetn) begin
            fail_count = 0;
            axis_x <= twn_pkg::BASIS_X_RESET;
            axis_y <= twn_pkg::BASIS_Y_RESET;
            axis_z <= twn_pkg::BASIS_Z_RESET;
            org    <= twn_pkg::ORIGIN_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    twn_pkg::REG_BASIS_X: axis_x <= cfg_data;
                    twn_pkg::REG_BASIS_Y: axis_y <= cfg_data;
                    twn_pkg::REG_BASIS_Z: axis_z <= cfg_data;
                    twn_pkg::REG_ORIGIN:  org    <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                p = '{s_a_x, s_a_y, s_a_z, s_b_x, s_b_y, s_b_z, s_c_x, s_c_y, s_c_z};
                predict_triangle(p, s_mesh_end_in);
            end
            if (m_valid && m_ready) begin
                if (vertex_q.size() == 0) begin
                    report("extra result transaction", 1, 0);
                end else begin
                    e = vertex_q.pop_front();
                    if (m_world_x != e.wx) report("world_x", m_world_x, e.wx);
                    if (m_world_y != e.wy) report("world_y", m_world_y, e.wy);
                    if (m_world_z != e.wz) report("world_z", m_world_z, e.wz);
                    if (m_normal_x != e.nx) report("normal_x", m_normal_x, e.nx);
                    if (m_normal_y != e.ny) report("normal_y", m_normal_y, e.ny);
                    if (m_normal_z != e.nz) report("normal_z", m_normal_z, e.nz);
                    if (m_vertex_last != e.last) report("vertex_last", m_vertex_last, e.last);
                    if (m_mesh_end_out != e.mend) report("mesh_end_out", m_mesh_end_out, e.mend);
                end
            end
        end
    end
endmodule

// ===== dv/tb.sv =====
// testbench top for the triangle world transform and normal core: stimulus and verdict
`timescale 1ns / 1ps
module tb;
    localparam logic [twn_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

    logic aclk = 0, aresetn = 0;
    logic cfg_valid = 0, cfg_ready;
    logic [twn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [twn_pkg::CFG_W-1:0] cfg_data = '0;
    logic s_valid = 0, s_ready;
    logic signed [15:0] s_a_x = 0, s_a_y = 0, s_a_z = 0, s_b_x = 0, s_b_y = 0, s_b_z = 0;
    logic signed [15:0] s_c_x = 0, s_c_y = 0, s_c_z = 0;
    logic s_mesh_end_in = 0;
    logic m_valid, m_ready = 0;
    logic signed [twn_pkg::WORLD_W-1:0] m_world_x, m_world_y, m_world_z;
    logic signed [twn_pkg::NORM_W-1:0] m_normal_x, m_normal_y, m_normal_z;
    logic m_vertex_last, m_mesh_end_out;
    int fail_count, pending;
    int send_idle = 0, recv_stall = 0;
    longint cycles = 0;

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    triangle_world_transform_normal_core dut (.*);
    twn_checker chk (.*);

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [twn_pkg::CFG_IDX_W-1:0] idx, logic [twn_pkg::CFG_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic send_tri(logic [15:0] c[9], logic mend);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        {s_a_x, s_a_y, s_a_z} <= {c[0], c[1], c[2]};
        {s_b_x, s_b_y, s_b_z} <= {c[3], c[4], c[5]};
        {s_c_x, s_c_y, s_c_z} <= {c[6], c[7], c[8]};
        s_mesh_end_in <= mend;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(2048) - 1024);
            default: return 16'(($urandom_range(1) ? 16'h7fff : 16'h8000) ^ $urandom_range(3));
        endcase
    endfunction

    function automatic logic [twn_pkg::CFG_W-1:0] rand_basis();
        logic [twn_pkg::CFG_W-1:0] r;
        for (int k = 0; k < 3; k++)
            r[16*k +: 16] = ($urandom_range(3) == 0) ? 16'($urandom) :
                            16'($urandom_range(32768) - 16384);
        return r;
    endfunction

    initial begin
        logic [15:0] c[9];
        int mode;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, degenerate and identity cases
        c = '{default: 16'h0};
        send_tri(c, 0);
        c = '{16'h0100, 0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100};
        send_tri(c, 0);
        c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
              16'h7fff, 16'h8000, 16'h7fff};
        send_tri(c, 1);
        c = '{0, 0, 0, 16'h0100, 16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h0200};
        send_tri(c, 0);
        c = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
              16'hffff, 16'h0001, 16'h0000};
        send_tri(c, 1);
        c = '{16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234,
              16'h1234, 16'h1234, 16'h1234};
        send_tri(c, 0);
        drain();

        write_reg(twn_pkg::REG_BASIS_X, 48'h7fff_7fff_7fff);
        write_reg(twn_pkg::REG_BASIS_Y, 48'h8000_8000_8000);
        write_reg(twn_pkg::REG_BASIS_Z, 48'hc000_4000_7fff);
        write_reg(twn_pkg::REG_ORIGIN,  48'h7fff_8000_7fff);
        write_reg(REG_UNUSED, 48'hffff_ffff_ffff);
        for (int i = 0; i < 6; i++) begin
            foreach (c[k]) c[k] = rand_coord(i % 3);
            send_tri(c, i[0]);
        end
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 80; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 80; end
                default: begin send_idle = 32; recv_stall = 32; end
            endcase
            if (ph == 7) begin
                write_reg(twn_pkg::REG_BASIS_X, twn_pkg::BASIS_X_RESET);
                write_reg(twn_pkg::REG_BASIS_Y, twn_pkg::BASIS_Y_RESET);
                write_reg(twn_pkg::REG_BASIS_Z, twn_pkg::BASIS_Z_RESET);
                write_reg(twn_pkg::REG_ORIGIN, twn_pkg::ORIGIN_RESET);
            end else begin
                write_reg(twn_pkg::REG_BASIS_X, rand_basis());
                write_reg(twn_pkg::REG_BASIS_Y, rand_basis());
                write_reg(twn_pkg::REG_BASIS_Z, rand_basis());
                write_reg(twn_pkg::REG_ORIGIN, twn_pkg::CFG_W'({$urandom, $urandom}));
            end
            for (int i = 0; i < 49; i++) begin
                mode = $urandom_range(2);
                foreach (c[k]) c[k] = rand_coord(mode);
                if ($urandom_range(9) == 0) {c[3], c[4], c[5]} = {c[0], c[1], c[2]};
                send_tri(c, $urandom_range(7) == 0);
                if (i == 20 && ph == 1) begin
                    s_valid <= 0;
                    @(posedge aclk);
                    while (pending != 0) @(posedge aclk);
                end
            end
            drain();
        end

        recv_stall = 0;
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
